// ----- sv/i2r_pkg.sv -----
`default_nettype none
package i2r_pkg;

	// input and conversion sizes
	localparam int NumW = 14;
	localparam int DigW = 4;
	localparam int Steps = NumW;
	localparam int StepW = $clog2(Steps);
	localparam logic [NumW-1:0] NumMax = 14'd9999;

	// output and sequencing sizes
	localparam int SymW = 7;
	localparam int IdxW = 3;
	localparam int LenW = 4;

	typedef logic [DigW-1:0] digit_t;
	typedef logic [IdxW-1:0] sym_idx_t;
	typedef logic [LenW-1:0] len_t;

	// decimal digits of one number, thousands first
	typedef struct packed {
		digit_t th;
		digit_t hu;
		digit_t te;
		digit_t on;
	} bcd_t;

	// symbol indexes, in order of value
	localparam sym_idx_t IdxI = 3'd0;
	localparam sym_idx_t IdxV = 3'd1;
	localparam sym_idx_t IdxX = 3'd2;
	localparam sym_idx_t IdxL = 3'd3;
	localparam sym_idx_t IdxC = 3'd4;
	localparam sym_idx_t IdxD = 3'd5;
	localparam sym_idx_t IdxM = 3'd6;

	// ASCII codes of the symbols
	localparam logic [SymW-1:0] ChI = 7'h49;
	localparam logic [SymW-1:0] ChV = 7'h56;
	localparam logic [SymW-1:0] ChX = 7'h58;
	localparam logic [SymW-1:0] ChL = 7'h4C;
	localparam logic [SymW-1:0] ChC = 7'h43;
	localparam logic [SymW-1:0] ChD = 7'h44;
	localparam logic [SymW-1:0] ChM = 7'h4D;

	localparam digit_t DigFour = 4'd4;
	localparam digit_t DigFive = 4'd5;
	localparam digit_t DigNine = 4'd9;

	function automatic logic [SymW-1:0] sym_char(sym_idx_t idx);
		logic [SymW-1:0] ch;
		unique case (idx)
			IdxI: ch = ChI;
			IdxV: ch = ChV;
			IdxX: ch = ChX;
			IdxL: ch = ChL;
			IdxC: ch = ChC;
			IdxD: ch = ChD;
			IdxM: ch = ChM;
			default: ch = ChI;
		endcase
		return ch;
	endfunction

	// number of characters a digit expands to
	function automatic len_t dig_len(logic is_th, digit_t d);
		len_t len;
		if (is_th)
			len = d;
		else if (d == DigFour || d == DigNine)
			len = 4'd2;
		else if (d >= DigFive)
			len = d - DigFour;
		else
			len = d;
		return len;
	endfunction

	// symbol at position j of a digit whose unit symbol is u
	function automatic sym_idx_t dig_sym(logic is_th, digit_t d, sym_idx_t u, len_t j);
		sym_idx_t idx;
		if (is_th)
			idx = IdxM;
		else if (d == DigFour)
			idx = (j == '0) ? u : u + 3'd1;
		else if (d == DigNine)
			idx = (j == '0) ? u : u + 3'd2;
		else if (d >= DigFive)
			idx = (j == '0) ? u + 3'd1 : u;
		else
			idx = u;
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- sv/i2r_front.sv -----
`default_nettype none
module i2r_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [i2r_pkg::NumW-1:0]    number,
	output logic                             busy,
	output logic                             push_valid,
	output i2r_pkg::bcd_t                    push_data,
	input  wire logic                        push_ready
);

	typedef enum logic [1:0] {
		FrIdle,
		FrConv,
		FrPush
	} fr_state_t;

	fr_state_t                     state_q;
	logic [i2r_pkg::NumW-1:0]      bin_q;
	logic [i2r_pkg::StepW-1:0]     cnt_q;
	i2r_pkg::bcd_t                 bcd_q;
	logic [4*i2r_pkg::DigW-1:0]    adj;

	// add three to every digit of five or more before the shift
	always_comb begin
		adj = bcd_q;
		for (int k = 0; k < 4; k++) begin
			if (adj[k*i2r_pkg::DigW +: i2r_pkg::DigW] >= i2r_pkg::DigFive)
				adj[k*i2r_pkg::DigW +: i2r_pkg::DigW] =
					adj[k*i2r_pkg::DigW +: i2r_pkg::DigW] + 4'd3;
		end
	end

	assign busy       = (state_q != FrIdle);
	assign push_valid = (state_q == FrPush) && (bcd_q != '0);
	assign push_data  = bcd_q;

	// take a number, convert one bit a cycle, hand the digits on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FrIdle;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				FrIdle: begin
					if (start) begin
						bin_q   <= (number > i2r_pkg::NumMax) ? i2r_pkg::NumMax : number;
						bcd_q   <= '0;
						cnt_q   <= '0;
						state_q <= FrConv;
					end
				end
				FrConv: begin
					bcd_q <= {adj[4*i2r_pkg::DigW-2:0], bin_q[i2r_pkg::NumW-1]};
					bin_q <= {bin_q[i2r_pkg::NumW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == i2r_pkg::StepW'(i2r_pkg::Steps - 1))
						state_q <= FrPush;
				end
				FrPush: begin
					// drop zero, it has no characters
					if (bcd_q == '0 || push_ready)
						state_q <= FrIdle;
				end
				default: state_q <= FrIdle;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/i2r_queue.sv -----
`default_nettype none
module i2r_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	input  wire i2r_pkg::bcd_t push_data,
	output logic               push_ready,
	output logic               pop_valid,
	output i2r_pkg::bcd_t      pop_data,
	input  wire logic          pop_ready
);

	i2r_pkg::bcd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

// ----- sv/i2r_back.sv -----
`default_nettype none
module i2r_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      pop_valid,
	input  wire i2r_pkg::bcd_t             pop_data,
	output logic                           pop_ready,
	output logic                           valid,
	output logic [i2r_pkg::SymW-1:0]       symbol,
	output logic                           last
);

	localparam logic [1:0] PosTh = 2'd0;
	localparam logic [1:0] PosHu = 2'd1;
	localparam logic [1:0] PosTe = 2'd2;
	localparam logic [1:0] PosOn = 2'd3;

	logic                         act_q;
	i2r_pkg::bcd_t                dig_q;
	logic [1:0]                   pos_q;
	i2r_pkg::len_t                j_q;
	logic                         valid_q;
	logic [i2r_pkg::SymW-1:0]     symbol_q;
	logic                         last_q;

	i2r_pkg::digit_t              cur_d;
	i2r_pkg::sym_idx_t            unit;
	logic                         rest_zero;
	logic                         is_th;
	i2r_pkg::len_t                len;
	logic                         end_dig;

	// pick the current digit, its unit symbol and whether anything follows
	always_comb begin
		unique case (pos_q)
			PosTh: begin
				cur_d     = dig_q.th;
				unit      = i2r_pkg::IdxM;
				rest_zero = (dig_q.hu == '0) && (dig_q.te == '0) && (dig_q.on == '0);
			end
			PosHu: begin
				cur_d     = dig_q.hu;
				unit      = i2r_pkg::IdxC;
				rest_zero = (dig_q.te == '0) && (dig_q.on == '0);
			end
			PosTe: begin
				cur_d     = dig_q.te;
				unit      = i2r_pkg::IdxX;
				rest_zero = (dig_q.on == '0);
			end
			PosOn: begin
				cur_d     = dig_q.on;
				unit      = i2r_pkg::IdxI;
				rest_zero = 1'b1;
			end
			default: begin
				cur_d     = dig_q.on;
				unit      = i2r_pkg::IdxI;
				rest_zero = 1'b1;
			end
		endcase
	end

	assign is_th     = (pos_q == PosTh);
	assign len       = i2r_pkg::dig_len(is_th, cur_d);
	assign end_dig   = (len == '0) || (j_q == len - 4'd1);
	assign pop_ready = !act_q;

	assign valid  = valid_q;
	assign symbol = symbol_q;
	assign last   = last_q;

	// load a transaction, then emit one character a cycle, with a gap where an empty digit is skipped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			valid_q <= 1'b0;
			pos_q   <= PosTh;
			j_q     <= '0;
		end else begin
			valid_q <= 1'b0;
			if (!act_q) begin
				if (pop_valid) begin
					act_q <= 1'b1;
					dig_q <= pop_data;
					pos_q <= PosTh;
					j_q   <= '0;
				end
			end else begin
				if (len != '0) begin
					valid_q  <= 1'b1;
					symbol_q <= i2r_pkg::sym_char(i2r_pkg::dig_sym(is_th, cur_d, unit, j_q));
					last_q   <= end_dig && rest_zero;
				end
				if (end_dig) begin
					j_q <= '0;
					if (pos_q == PosOn)
						act_q <= 1'b0;
					else
						pos_q <= pos_q + 2'd1;
				end else begin
					j_q <= j_q + 4'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- sv/integer_to_roman_numeral.sv -----
`default_nettype none
// Integer to Roman numeral converter.
// Input channel: drive number with start high; the transaction is taken at a
// rising edge where start is high and busy is low. Values above 9999 are
// treated as 9999.
// Output channel: one ASCII character (I V X L C D M) per cycle marked by
// valid, with gaps while an entry loads or a zero digit is skipped; thousands
// first, with last high on the final character. The receiver cannot stall;
// each character is shown for exactly one cycle.
// Zero produces no characters at all.
// Front end: a binary to decimal converter, one input bit a cycle in 14
// conversion steps; busy stays high through conversion and hand-over, so a
// new number is taken only after the digits are handed on, later if the
// two-entry digit queue is full.
// Back end: one character a cycle, with a load step for each entry and an
// idle step for every zero digit skipped; it takes a new entry only when the
// last one is done. 9888 gives the longest output, 21 characters.
// Reset clears the queue and all control state; no characters are pending.
module integer_to_roman_numeral (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [i2r_pkg::NumW-1:0]   number,
	output logic                            busy,
	output logic                            valid,
	output logic [i2r_pkg::SymW-1:0]        symbol,
	output logic                            last
);

	logic          push_valid;
	logic          push_ready;
	i2r_pkg::bcd_t push_data;
	logic          pop_valid;
	logic          pop_ready;
	i2r_pkg::bcd_t pop_data;

	i2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.number     (number),
		.busy       (busy),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	i2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	i2r_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.valid     (valid),
		.symbol    (symbol),
		.last      (last)
	);

endmodule
`default_nettype wire

// ----- sv/i2r_checker.sv -----
`default_nettype none
module i2r_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       start,
	input wire logic [i2r_pkg::NumW-1:0]   number,
	input wire logic                       busy,
	input wire logic                       valid,
	input wire logic [i2r_pkg::SymW-1:0]   symbol,
	input wire logic                       last
);

	// every character is a Roman symbol
	a_sym_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (symbol == i2r_pkg::ChI || symbol == i2r_pkg::ChV ||
			symbol == i2r_pkg::ChX || symbol == i2r_pkg::ChL ||
			symbol == i2r_pkg::ChC || symbol == i2r_pkg::ChD ||
			symbol == i2r_pkg::ChM))
		else $error("illegal symbol");

	// an accepted transaction keeps the front end occupied
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after acceptance");

	// a five-symbol is never followed straight away by itself within a numeral
	a_no_double_five: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last && (symbol == i2r_pkg::ChV || symbol == i2r_pkg::ChL ||
			symbol == i2r_pkg::ChD)) |=> !(valid && symbol == $past(symbol)))
		else $error("five-symbol repeated");

	// a numeral's end is followed by a gap before the next one
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("character straight after last");

	// number is only watched through the handshake
	a_number_known: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> !$isunknown(number))
		else $error("unknown number accepted");

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.number (number),
	.busy   (busy),
	.valid  (valid),
	.symbol (symbol),
	.last   (last)
);
`default_nettype wire
